### rtl/lrlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlc_pkg: shared types and constants of the latch record line checker
// Holds the request payload structs, the line template and the field codes
// that sit in the template where a decimal or hex field is expected.
// ----------------------------------------------------------------------------
package lrlc_pkg;

    // One character of the line and its end-of-line mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } char_req_t;

    // Checked record; every field but ok is zero when ok is low.
    typedef struct packed {
        logic        ok;
        logic        install_flag;
        logic [63:0] install_time;
        logic        exposure_flag;
        logic [63:0] exposure_time;
        logic        event_flag;
        logic [63:0] event_time;
        logic [1:0]  event_code;
        logic [31:0] event_word;
    } rec_req_t;

    // Field codes that stand in the template in place of a field.
    localparam logic [7:0] F_IVALID = 8'd1;
    localparam logic [7:0] F_ITIME  = 8'd2;
    localparam logic [7:0] F_XVALID = 8'd3;
    localparam logic [7:0] F_XTIME  = 8'd4;
    localparam logic [7:0] F_EVALID = 8'd5;
    localparam logic [7:0] F_ETIME  = 8'd6;
    localparam logic [7:0] F_KIND   = 8'd7;
    localparam logic [7:0] F_HEX    = 8'd8;

    localparam logic [7:0] CHR_0  = 8'h30;
    localparam logic [7:0] CHR_9  = 8'h39;
    localparam logic [7:0] CHR_A  = 8'h61;
    localparam logic [7:0] CHR_F  = 8'h66;
    localparam logic [7:0] CHR_NL = 8'h0a;

    localparam int TMPL_LEN = 82;
    localparam int POS_W    = 7;

    localparam logic [TMPL_LEN*8-1:0] TMPL_STR = {
        "v=1 install",
        "_v=\001",
        " install",
        "_ns=\002",
        " gate_v=\003",
        " gate_ns=\004",
        " event_v=\005",
        " event",
        "_ns=\006",
        " kind=\007",
        " raw=\010\n"
    };

    // Template character at a position; zero beyond the end.
    function automatic logic [7:0] tmpl_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        c = 8'd0;
        if (int'(pos) < TMPL_LEN) begin
            c = TMPL_STR[(TMPL_LEN - 1 - int'(pos)) * 8 +: 8];
        end
        return c;
    endfunction

    // Largest value a decimal field may hold.
    function automatic logic [63:0] field_max(input logic [7:0] code);
        logic [63:0] m;
        m = 64'd1;
        if (code == F_KIND) begin
            m = 64'd3;
        end else if (code == F_ITIME || code == F_XTIME || code == F_ETIME) begin
            m = '1;
        end
        return m;
    endfunction

endpackage

### rtl/latch_record_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latch_record_line_checker: template check of one latch record text line
// Parses a line a character at a time, captures its fields and reports one
// checked record on the character that carries the end-of-line mark.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   char      in         char_valid/char_ready   char_data  (char_req_t)
//   rec       out        rec_valid/rec_ready     rec_data   (rec_req_t)
//
// Each character request is parsed while it sits in the input register, so a
// character can be taken in every cycle unless the char side stalls as below.
// A character without the end-of-line mark never waits on the output side;
// one with the mark waits in the input register while an earlier record is
// still held in the result register, and only that stalls the char side.
// The record is written to the result register when its last character is
// parsed in the input register while the result register is free, and stays
// there until rec_ready takes it.
// Reset (rst_n low) empties both registers and clears all parser state.
//
module latch_record_line_checker
    import lrlc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  char_req_t char_data,
    output logic      rec_valid,
    input  logic      rec_ready,
    output rec_req_t  rec_data
);

    // Input register holding the character being parsed.
    logic      s1_valid_reg, s1_valid_next;
    char_req_t s1_data_reg;

    // Result register.
    logic     out_valid_reg;
    rec_req_t out_data_reg, out_data_next;

    // Parser state.
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [63:0]      acc_reg, acc_next;
    logic             dig_reg, dig_next;
    logic             lz_reg, lz_next;
    logic [3:0]       hex_cnt_reg, hex_cnt_next;
    logic             err_reg, err_next;

    // Captured fields.
    logic        h_ivalid_reg, h_ivalid_next;
    logic [63:0] h_itime_reg, h_itime_next;
    logic        h_xvalid_reg, h_xvalid_next;
    logic [63:0] h_xtime_reg, h_xtime_next;
    logic        h_evalid_reg, h_evalid_next;
    logic [63:0] h_etime_reg, h_etime_next;
    logic [1:0]  h_kind_reg, h_kind_next;
    logic [31:0] h_word_reg, h_word_next;

    logic        char_acc;
    logic        out_free;
    logic        proc;
    logic        proc_last;

    logic [7:0]  b;
    logic [7:0]  t;
    logic [7:0]  t2;
    logic        is_dec;
    logic        is_digit;
    logic        hex_ok;
    logic [3:0]  nib;
    logic [63:0] d;
    logic [67:0] dec_sum;
    logic        dec_over;
    logic [POS_W-1:0] pos_inc;

    logic        store_en;
    logic [7:0]  store_code;
    logic [63:0] store_val;

    logic        word_ok;
    logic        fields_ok;
    logic        rec_ok;

    // ------------------------------------------------------------------
    // Handshake. A character that closes the line needs a free result slot.
    // ------------------------------------------------------------------
    assign out_free   = !out_valid_reg || rec_ready;
    assign proc       = s1_valid_reg && (!s1_data_reg.last_byte || out_free);
    assign proc_last  = proc && s1_data_reg.last_byte;
    assign char_ready = !s1_valid_reg || proc;
    assign char_acc   = char_valid && char_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (char_acc) begin
            s1_valid_next = 1'b1;
        end else if (proc) begin
            s1_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Character classification and decimal / hex arithmetic.
    // The times-ten step is two shifts and an add; the 68-bit sum makes
    // both the 64-bit overflow and the small-field maximum one compare.
    // ------------------------------------------------------------------
    assign b        = s1_data_reg.in_byte;
    assign t        = tmpl_char(pos_reg);
    assign pos_inc  = pos_reg + POS_W'(1);
    assign t2       = tmpl_char(pos_inc);
    assign is_dec   = (t >= F_IVALID) && (t <= F_KIND);
    assign is_digit = (b >= CHR_0) && (b <= CHR_9);
    assign hex_ok   = is_digit || ((b >= CHR_A) && (b <= CHR_F));
    assign nib      = is_digit ? b[3:0] : (b[3:0] + 4'd9);
    assign d        = {60'd0, b[3:0]};
    assign dec_sum  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {4'd0, d};
    assign dec_over = dec_sum > {4'd0, field_max(t)};

    // ------------------------------------------------------------------
    // Parser next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        dig_next     = dig_reg;
        lz_next      = lz_reg;
        hex_cnt_next = hex_cnt_reg;
        err_next     = err_reg;
        store_en     = 1'b0;
        store_code   = t;
        store_val    = acc_reg;

        if (proc && !err_reg) begin
            priority if (int'(pos_reg) >= TMPL_LEN) begin
                err_next = 1'b1;
            end else if (t == F_HEX) begin
                if (!hex_ok) begin
                    err_next = 1'b1;
                end else begin
                    acc_next = {32'd0, acc_reg[27:0], nib};
                    if (hex_cnt_reg == 4'd7) begin
                        store_en     = 1'b1;
                        store_val    = {32'd0, acc_reg[27:0], nib};
                        acc_next     = '0;
                        hex_cnt_next = '0;
                        pos_next     = pos_inc;
                    end else begin
                        hex_cnt_next = hex_cnt_reg + 4'd1;
                    end
                end
            end else if (is_dec) begin
                if (is_digit) begin
                    if (lz_reg || dec_over) begin
                        err_next = 1'b1;
                    end else begin
                        if (!dig_reg && b[3:0] == 4'd0) begin
                            lz_next = 1'b1;
                        end
                        dig_next = 1'b1;
                        acc_next = dec_sum[63:0];
                    end
                end else if (!dig_reg) begin
                    err_next = 1'b1;
                end else begin
                    // Field closed: store it, then match the separator after it.
                    store_en = 1'b1;
                    acc_next = '0;
                    dig_next = 1'b0;
                    lz_next  = 1'b0;
                    pos_next = pos_inc;
                    if (int'(pos_inc) >= TMPL_LEN || b != t2) begin
                        err_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + POS_W'(2);
                    end
                end
            end else if (b != t) begin
                err_next = 1'b1;
            end else begin
                pos_next = pos_inc;
            end
        end

        if (proc_last) begin
            pos_next     = '0;
            acc_next     = '0;
            dig_next     = 1'b0;
            lz_next      = 1'b0;
            hex_cnt_next = '0;
            err_next     = 1'b0;
        end
    end

    // Captured field updates; everything returns to zero after each line.
    always_comb
    begin
        h_ivalid_next = h_ivalid_reg;
        h_itime_next  = h_itime_reg;
        h_xvalid_next = h_xvalid_reg;
        h_xtime_next  = h_xtime_reg;
        h_evalid_next = h_evalid_reg;
        h_etime_next  = h_etime_reg;
        h_kind_next   = h_kind_reg;
        h_word_next   = h_word_reg;

        if (store_en) begin
            unique case (store_code)
                F_IVALID: h_ivalid_next = store_val[0];
                F_ITIME:  h_itime_next  = store_val;
                F_XVALID: h_xvalid_next = store_val[0];
                F_XTIME:  h_xtime_next  = store_val;
                F_EVALID: h_evalid_next = store_val[0];
                F_ETIME:  h_etime_next  = store_val;
                F_KIND:   h_kind_next   = store_val[1:0];
                default:  h_word_next   = store_val[31:0];
            endcase
        end

        if (proc_last) begin
            h_ivalid_next = 1'b0;
            h_itime_next  = '0;
            h_xvalid_next = 1'b0;
            h_xtime_next  = '0;
            h_evalid_next = 1'b0;
            h_etime_next  = '0;
            h_kind_next   = '0;
            h_word_next   = '0;
        end
    end

    // ------------------------------------------------------------------
    // Cross-field checks. A line can only complete on its closing newline,
    // which stores no field, so the held registers are already final here.
    // ------------------------------------------------------------------
    always_comb
    begin
        word_ok = 1'b0;
        unique case (h_kind_reg)
            2'd1, 2'd2: word_ok = h_word_reg[0] && (h_word_reg[7:1] == 7'd0) &&
                                  (h_word_reg[11:8] == {2'b00, h_kind_reg});
            2'd3:       word_ok = !h_word_reg[0] && (h_word_reg[5:1] == 5'd0) &&
                                  (h_word_reg[9:6] == 4'd1);
            default:    word_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        fields_ok = 1'b1;
        if (!h_ivalid_reg || h_itime_reg == 64'd0) begin
            fields_ok = 1'b0;
        end
        if (!h_xvalid_reg) begin
            if (h_xtime_reg != 64'd0) begin
                fields_ok = 1'b0;
            end
        end else if (h_xtime_reg == 64'd0 || h_itime_reg > h_xtime_reg) begin
            fields_ok = 1'b0;
        end
        if (!h_evalid_reg) begin
            if (h_etime_reg != 64'd0 || h_kind_reg != 2'd0 || h_word_reg != 32'd0) begin
                fields_ok = 1'b0;
            end
        end else if (!h_xvalid_reg || h_etime_reg == 64'd0 ||
                     h_etime_reg < h_xtime_reg || !word_ok) begin
            fields_ok = 1'b0;
        end
    end

    // The current parser registers and character decide the record, before the line reset.
    always_comb
    begin
        rec_ok = 1'b0;
        if (!err_reg && !(int'(pos_reg) >= TMPL_LEN) && t == CHR_NL && b == t) begin
            rec_ok = (int'(pos_inc) == TMPL_LEN) && fields_ok;
        end
    end

    always_comb
    begin
        out_data_next                = '0;
        out_data_next.ok             = rec_ok;
        if (rec_ok) begin
            out_data_next.install_flag  = h_ivalid_reg;
            out_data_next.install_time  = h_itime_reg;
            out_data_next.exposure_flag = h_xvalid_reg;
            out_data_next.exposure_time = h_xtime_reg;
            out_data_next.event_flag    = h_evalid_reg;
            out_data_next.event_time    = h_etime_reg;
            out_data_next.event_code    = h_kind_reg;
            out_data_next.event_word    = h_word_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            dig_reg       <= 1'b0;
            lz_reg        <= 1'b0;
            hex_cnt_reg   <= '0;
            err_reg       <= 1'b0;
            h_ivalid_reg  <= 1'b0;
            h_itime_reg   <= '0;
            h_xvalid_reg  <= 1'b0;
            h_xtime_reg   <= '0;
            h_evalid_reg  <= 1'b0;
            h_etime_reg   <= '0;
            h_kind_reg    <= '0;
            h_word_reg    <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (proc_last) begin
                out_valid_reg <= 1'b1;
            end else if (rec_ready) begin
                out_valid_reg <= 1'b0;
            end
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            dig_reg      <= dig_next;
            lz_reg       <= lz_next;
            hex_cnt_reg  <= hex_cnt_next;
            err_reg      <= err_next;
            h_ivalid_reg <= h_ivalid_next;
            h_itime_reg  <= h_itime_next;
            h_xvalid_reg <= h_xvalid_next;
            h_xtime_reg  <= h_xtime_next;
            h_evalid_reg <= h_evalid_next;
            h_etime_reg  <= h_etime_next;
            h_kind_reg   <= h_kind_next;
            h_word_reg   <= h_word_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (char_acc) begin
            s1_data_reg <= char_data;
        end
        if (proc_last) begin
            out_data_reg <= out_data_next;
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) <= TMPL_LEN)
        else $error("template position past the end of the template");

    a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
        hex_cnt_reg < 4'd8)
        else $error("hex digit count out of range");

    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        proc_last |=> (pos_reg == '0) && !err_reg && (acc_reg == '0) && !h_ivalid_reg)
        else $error("parser state not cleared after the last character");

    a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.ok |->
            (out_data_reg.install_time == '0) && (out_data_reg.event_word == '0) &&
            !out_data_reg.install_flag && (out_data_reg.event_code == '0))
        else $error("failed record carries nonzero fields");

    a_ok_install: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.ok |->
            out_data_reg.install_flag && (out_data_reg.install_time != '0))
        else $error("passed record without a valid install time");

endmodule

### sim/latch_record_line_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latch_record_line_checker_test: self-checking bench of the line checker
// Streams latch record text lines into the block a character request at a
// time and checks every record request against a parser kept in the bench.
// ----------------------------------------------------------------------------
module latch_record_line_checker_test
    import lrlc_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int LINES_PER_PHASE = 1;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_ready;
    char_req_t char_data = '0;
    logic      rec_valid;
    logic      rec_ready = 1'b0;
    rec_req_t  rec_data;

    latch_record_line_checker uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_data   (rec_data)
    );

    // Character requests waiting to be offered, and the records that the
    // bench parser has predicted but the block has not delivered yet.
    char_req_t char_queue[$];
    rec_req_t  expected_records[$];

    // Idle chances in percent for the two sides, set per phase; the
    // directed lines run with the settings of the first phase.
    int send_idle = 6;
    int recv_idle = 60;

    // The receiver hold-off is requested by bumping hold_asks; the ready
    // process notices the change and counts the stretch down on its own.
    int hold_asks = 0;
    int hold_taken = 0;
    int hold_left = 0;

    int   cycle_count = 0;
    bit   timed_out = 1'b0;
    int   mismatch_count = 0;
    int   record_count = 0;
    logic char_took = 1'b0;

    // Parser state of the bench: where we are in the template, the number
    // being gathered, and the fields captured so far on this line.
    int          tmpl_pos = 0;
    logic [63:0] num_acc = '0;
    bit          have_digit = 1'b0;
    bit          zero_lead = 1'b0;
    int          hex_count = 0;
    bit          line_bad = 1'b0;
    rec_req_t    captured = '0;

    initial begin
        forever begin
            #4 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Bench parser
    // ------------------------------------------------------------------

    // Template character at position p; the field codes stand where a
    // number is expected.
    function automatic logic [7:0] template_char(input int p);
        return TMPL_STR[(TMPL_LEN - 1 - p) * 8 +: 8];
    endfunction

    // Largest value the decimal field with code c may carry.
    function automatic logic [63:0] field_limit(input logic [7:0] c);
        logic [63:0] lim;
        case (c)
            F_KIND:                     lim = 64'd3;
            F_ITIME, F_XTIME, F_ETIME:  lim = '1;
            default:                    lim = 64'd1;
        endcase
        return lim;
    endfunction

    // Cross-field rules that a well-formed line must also satisfy.
    function automatic bit record_consistent(input rec_req_t r);
        if (!r.install_flag || r.install_time == 0) return 1'b0;
        if (!r.exposure_flag) begin
            if (r.exposure_time != 0) return 1'b0;
        end else if (r.exposure_time == 0 || r.install_time > r.exposure_time) begin
            return 1'b0;
        end
        if (!r.event_flag) begin
            return r.event_time == 0 && r.event_code == 0 && r.event_word == 0;
        end
        if (!r.exposure_flag || r.event_time == 0 || r.event_time < r.exposure_time
            || r.event_code == 0) begin
            return 1'b0;
        end
        // Kind 3 carries a different bit layout in the raw word than 1 and 2.
        if (r.event_code == 2'd3) begin
            return !r.event_word[0] && r.event_word[5:1] == 0 && r.event_word[9:6] == 4'd1;
        end
        return r.event_word[0] && r.event_word[7:1] == 0
            && r.event_word[11:8] == {2'b00, r.event_code};
    endfunction

    // Advance the parser by one character. Any departure from the template
    // sets line_bad, after which the rest of the line is ignored.
    task automatic parse_char(input logic [7:0] b);
        logic [7:0]  t;
        logic [3:0]  nib;
        logic [63:0] d;
        logic [63:0] lim;
        if (tmpl_pos >= TMPL_LEN) begin
            // Anything past the closing newline spoils the line.
            line_bad = 1'b1;
            return;
        end
        t = template_char(tmpl_pos);
        if (t == F_HEX) begin
            if (b >= CHR_0 && b <= CHR_9) begin
                nib = 4'(b - CHR_0);
            end else if (b >= CHR_A && b <= CHR_F) begin
                nib = 4'(b - CHR_A + 8'd10);
            end else begin
                line_bad = 1'b1;
                return;
            end
            num_acc = {32'd0, num_acc[27:0], nib};
            hex_count++;
            if (hex_count >= 8) begin
                captured.event_word = num_acc[31:0];
                num_acc = '0;
                hex_count = 0;
                tmpl_pos++;
            end
            return;
        end
        if (t >= F_IVALID && t <= F_KIND) begin
            if (b >= CHR_0 && b <= CHR_9) begin
                d = {56'd0, b - CHR_0};
                lim = field_limit(t);
                // A digit after a leading zero, or one that would push the
                // value past the field's maximum, is a mismatch.
                if (zero_lead || d > lim || num_acc > (lim - d) / 10) begin
                    line_bad = 1'b1;
                    return;
                end
                if (!have_digit && d == 0) zero_lead = 1'b1;
                have_digit = 1'b1;
                num_acc = num_acc * 10 + d;
                return;
            end
            // A non-digit closes the field, which must not be empty.
            if (!have_digit) begin
                line_bad = 1'b1;
                return;
            end
            case (t)
                F_IVALID: captured.install_flag  = num_acc[0];
                F_ITIME:  captured.install_time  = num_acc;
                F_XVALID: captured.exposure_flag = num_acc[0];
                F_XTIME:  captured.exposure_time = num_acc;
                F_EVALID: captured.event_flag    = num_acc[0];
                F_ETIME:  captured.event_time    = num_acc;
                default:  captured.event_code    = num_acc[1:0];
            endcase
            num_acc = '0;
            have_digit = 1'b0;
            zero_lead = 1'b0;
            tmpl_pos++;
            if (tmpl_pos >= TMPL_LEN) begin
                line_bad = 1'b1;
                return;
            end
            t = template_char(tmpl_pos);
        end
        if (b != t) line_bad = 1'b1;
        else tmpl_pos++;
    endtask

    // One accepted character request: parse it and, on the end-of-line
    // mark, predict the record and start over on a fresh line.
    task automatic take_char(input char_req_t c);
        rec_req_t r;
        if (!line_bad) parse_char(c.in_byte);
        if (c.last_byte) begin
            r = '0;
            if (!line_bad && tmpl_pos == TMPL_LEN && record_consistent(captured)) begin
                r = captured;
                r.ok = 1'b1;
            end
            expected_records.push_back(r);
            tmpl_pos = 0;
            num_acc = '0;
            have_digit = 1'b0;
            zero_lead = 1'b0;
            hex_count = 0;
            line_bad = 1'b0;
            captured = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string rec_text(input rec_req_t r);
        return $sformatf("ok=%0d iv=%0d it=%0d xv=%0d xt=%0d ev=%0d et=%0d kind=%0d word=%08h",
            r.ok, r.install_flag, r.install_time, r.exposure_flag, r.exposure_time,
            r.event_flag, r.event_time, r.event_code, r.event_word);
    endfunction

    // Only the first few mismatches are worth reading; the rest are counted.
    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    task automatic check_record(input rec_req_t got);
        rec_req_t want;
        string    bad;
        record_count++;
        if (expected_records.size() == 0) begin
            note_mismatch($sformatf("record %0d arrived with none expected: %s",
                record_count, rec_text(got)));
            return;
        end
        want = expected_records.pop_front();
        bad = "";
        if (got.ok !== want.ok)                       bad = {bad, " ok"};
        if (got.install_flag !== want.install_flag)   bad = {bad, " install_flag"};
        if (got.install_time !== want.install_time)   bad = {bad, " install_time"};
        if (got.exposure_flag !== want.exposure_flag) bad = {bad, " exposure_flag"};
        if (got.exposure_time !== want.exposure_time) bad = {bad, " exposure_time"};
        if (got.event_flag !== want.event_flag)       bad = {bad, " event_flag"};
        if (got.event_time !== want.event_time)       bad = {bad, " event_time"};
        if (got.event_code !== want.event_code)       bad = {bad, " event_code"};
        if (got.event_word !== want.event_word)       bad = {bad, " event_word"};
        if (bad != "") begin
            note_mismatch($sformatf("record %0d differs in%s\n  expected %s\n  actual   %s",
                record_count, bad, rec_text(want), rec_text(got)));
        end
    endtask

    // ------------------------------------------------------------------
    // Line building
    // ------------------------------------------------------------------

    function automatic string hex_text(input logic [31:0] w, input bit upper);
        string      s;
        logic [3:0] n;
        logic [7:0] ch;
        s = "";
        for (int i = 7; i >= 0; i--) begin
            n = w[i*4 +: 4];
            if (n < 10) ch = CHR_0 + n;
            else ch = (upper ? CHR_UPPER_A : CHR_A) + n - 8'd10;
            s = $sformatf("%s%c", s, ch);
        end
        return s;
    endfunction

    function automatic string record_text(input string f[8]);
        return $sformatf({"v=1 install", "_v=%s install", "_ns=%s gate_v=%s gate_ns=%s",
            " event_v=%s event", "_ns=%s kind=%s raw=%s\n"},
            f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
    endfunction

    // Queue a line of characters; the final one carries the end-of-line mark.
    task automatic push_line(input logic [7:0] q[$]);
        char_req_t c;
        for (int i = 0; i < q.size(); i++) begin
            c.in_byte = q[i];
            c.last_byte = (i == q.size() - 1);
            char_queue.push_back(c);
        end
    endtask

    task automatic push_text(input string s);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        push_line(q);
    endtask

    // A short burst of arbitrary bytes, any value, ending the line.
    task automatic push_noise(input int max_len);
        logic [7:0] q[$];
        int n;
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
        push_line(q);
    endtask

    // Timestamps over the whole 64-bit range with a bias to short numbers
    // and to the edges.
    function automatic logic [63:0] rand_stamp();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0:       v = 64'd0;
            1:       v = 64'd1;
            2:       v = '1;
            3:       v = {$urandom, $urandom};
            default: v = {$urandom, $urandom} >> $urandom_range(1, 63);
        endcase
        return v;
    endfunction

    // A record line with random content. Most lines follow the template and
    // the cross-field rules; some break a field, some break the line itself.
    task automatic push_record_line();
        logic [63:0] t0, t1, t2, tmp;
        logic        iv, xv, ev;
        logic [1:0]  kind;
        logic [31:0] word;
        string       f[8];
        string       s;
        logic [7:0]  q[$];
        int          k;
        int          cut;
        t0 = rand_stamp();
        t1 = rand_stamp();
        t2 = rand_stamp();
        if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
        if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
        if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
        if (t0 == 0 && $urandom_range(0, 3) != 0) t0 = 64'd1;
        iv = ($urandom_range(0, 19) != 0);
        xv = ($urandom_range(0, 3) != 0);
        ev = xv ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
        kind = 2'($urandom_range(1, 3));
        word = $urandom;
        if (kind == 2'd3) begin
            word[0] = 1'b0;
            word[5:1] = '0;
            word[9:6] = 4'd1;
        end else begin
            word[0] = 1'b1;
            word[7:1] = '0;
            word[11:8] = {2'b00, kind};
        end
        if (!xv && $urandom_range(0, 7) != 0) t1 = '0;
        if (!ev && $urandom_range(0, 7) != 0) begin
            t2 = '0;
            kind = '0;
            word = '0;
        end
        // Now and then every field is drawn independently of the others.
        if ($urandom_range(0, 9) == 0) begin
            iv = 1'($urandom);
            xv = 1'($urandom);
            ev = 1'($urandom);
            kind = 2'($urandom);
            word = $urandom;
            t0 = rand_stamp();
            t1 = rand_stamp();
            t2 = rand_stamp();
        end
        f[0] = $sformatf("%0d", iv);
        f[1] = $sformatf("%0d", t0);
        f[2] = $sformatf("%0d", xv);
        f[3] = $sformatf("%0d", t1);
        f[4] = $sformatf("%0d", ev);
        f[5] = $sformatf("%0d", t2);
        f[6] = $sformatf("%0d", kind);
        f[7] = hex_text(word, 1'b0);

        if ($urandom_range(0, 99) < 25) begin
            k = $urandom_range(0, 7);
            if (k == 7) begin
                case ($urandom_range(0, 3))
                    0: f[7] = f[7].substr(0, 6);
                    1: f[7] = {f[7], "a"};
                    2: f[7] = hex_text(word | 32'hf0, 1'b1);
                    default: f[7] = {f[7].substr(0, 6), "g"};
                endcase
            end else begin
                case ($urandom_range(0, 4))
                    0: f[k] = "";
                    1: f[k] = {"0", f[k]};
                    2: begin
                        // Value above the field's maximum; a time field may instead just gain a trailing 9.
                        if (k == 1 || k == 3 || k == 5) begin
                            f[k] = $urandom_range(0, 1) ? "18446744073709551616" : {f[k], "9"};
                        end else if (k == 6) begin
                            f[k] = $sformatf("%0d", $urandom_range(4, 9));
                        end else begin
                            f[k] = $sformatf("%0d", $urandom_range(2, 9));
                        end
                    end
                    3: f[k] = "00";
                    default: f[k] = "-1";
                endcase
            end
        end

        s = record_text(f);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 2))
                0: begin
                    // The end-of-line mark comes before the template is done.
                    cut = $urandom_range(1, q.size() - 1);
                    while (q.size() > cut) void'(q.pop_back());
                end
                1: begin
                    // Characters after the closing newline.
                    for (int i = $urandom_range(1, 3); i > 0; i--) begin
                        q.push_back(8'($urandom_range(0, 255)));
                    end
                end
                default: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
            endcase
        end
        push_line(q);
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    // Sender side. A request stays on the bus unchanged until the monitor
    // has seen it taken; only then may the next one, or a gap, follow.
    always @(negedge clk) begin
        if (rst_n && !(char_valid && !char_took)) begin
            if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                char_data  <= char_queue.pop_front();
                char_valid <= 1'b1;
            end else begin
                char_valid <= 1'b0;
            end
        end
    end

    // Receiver side. A requested hold-off keeps rec_ready low for a long
    // stretch so that records pile up and the block stalls its input.
    always @(negedge clk) begin
        if (!rst_n) begin
            rec_ready <= 1'b0;
        end else if (hold_left > 0) begin
            rec_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asks) begin
            hold_taken <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            rec_ready  <= 1'b0;
        end else begin
            rec_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Everything is sampled on the rising edge. An accepted character is
    // parsed before a delivered record is checked, so a record taken in the
    // same cycle as a line's end always finds its expectation queued.
    always @(posedge clk) begin
        if (rst_n) begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT) timed_out <= 1'b1;
            char_took <= char_valid && char_ready;
            if (char_valid && char_ready) take_char(char_data);
            if (rec_valid && rec_ready) check_record(rec_data);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------

    // Waits until every queued character is taken and every predicted
    // record has come out, or until the cycle limit is hit.
    task automatic wait_drained();
        while (!timed_out && (char_queue.size() != 0 || char_valid
                              || expected_records.size() != 0)) begin
            @(posedge clk);
        end
    endtask

    initial begin
        string      f[8];
        logic [7:0] q[$];

        // Directed lines: both field extremes, every kind, and the main
        // ways a line can go wrong.
        f = '{"1", "18446744073709551615", "1", "18446744073709551615",
              "1", "18446744073709551615", "1", "00000101"};
        push_text(record_text(f));
        f = '{"1", "1", "0", "0", "0", "0", "0", "00000000"};
        push_text(record_text(f));
        f = '{"1", "10", "1", "20", "1", "30", "2", "fffff201"};
        push_text(record_text(f));
        f = '{"1", "7", "1", "7", "1", "7", "3", "abcdec40"};
        push_text(record_text(f));
        // Time field one past the 64-bit maximum.
        f = '{"1", "18446744073709551616", "0", "0", "0", "0", "0", "00000000"};
        push_text(record_text(f));
        // Leading zero in front of more digits.
        f = '{"1", "007", "0", "0", "0", "0", "0", "00000000"};
        push_text(record_text(f));
        // A field with no digits at all.
        f = '{"1", "5", "", "0", "0", "0", "0", "00000000"};
        push_text(record_text(f));
        // Small field above its maximum.
        f = '{"2", "5", "0", "0", "0", "0", "0", "00000000"};
        push_text(record_text(f));
        // Extra characters after the newline.
        f = '{"1", "1", "0", "0", "0", "0", "0", "00000000"};
        push_text({record_text(f), "zz"});
        // Line cut short, a lone newline, and a lone top-bit byte.
        push_text("v=1 inst");
        push_text("\n");
        q.push_back(8'hff);
        push_line(q);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle = 6;  recv_idle = 60; end
                1: begin send_idle = 60; recv_idle = 6;  end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    // Hold the receiver off while a run of short lines keeps
                    // the sender busy.
                    hold_asks++;
                    for (int i = 0; i < 40; i++) push_noise(2);
                end
            endcase
            for (int i = 0; i < LINES_PER_PHASE; i++) begin
                if ($urandom_range(0, 99) < 15) push_noise(6);
                else push_record_line();
            end
            wait_drained();
        end

        // Let the pipeline settle in case something stray is still on its way.
        repeat (20) @(posedge clk);
        if (expected_records.size() != 0) begin
            note_mismatch($sformatf("%0d expected records never arrived",
                expected_records.size()));
        end
        if (!timed_out && mismatch_count == 0) begin
            $display("latch_record_line_checker: match");
        end else begin
            $display("latch_record_line_checker: mismatch");
        end
        $finish;
    end

endmodule
